// ===== hdl/mqjs_pkg.sv =====
// types, codes and helpers shared by the job scheduler modules
// no dependencies
package mqjs_pkg;

    localparam int FIFO_DEPTH = 2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NONE  = 2'd1;
    localparam logic [1:0] STAT_DELIV = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    typedef enum logic [2:0] {
        K_PUT    = 3'd0,
        K_GET    = 3'd1,
        K_ABORT  = 3'd2,
        K_DELETE = 3'd3,
        K_DISC   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WSCAN,
        S_WDELIV,
        S_EMIT,
        S_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        RET_EMIT,
        RET_FLUSH,
        RET_SCAN
    } t_ret;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  client;
        logic [2:0]  queue_sel;
        logic [7:0]  queue_mask;
        logic        wait_flag;
        logic [30:0] prio;
        logic [31:0] payload_tag;
        logic [31:0] target_id;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  dest_client;
        logic [31:0] out_id;
        logic [2:0]  out_queue;
        logic [30:0] out_prio;
        logic [31:0] out_payload;
        logic        last;
    } t_out;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  client;
        logic [2:0]  qsel;
        logic [7:0]  mask;
        logic        wait_flag;
        logic [30:0] prio;
        logic [31:0] payload;
        logic [31:0] tid;
    } t_req;

    typedef struct packed {
        logic [2:0]  queue;
        logic [30:0] prio;
        logic [31:0] id;
        logic [31:0] payload;
    } t_job;

    function automatic logic [2:0] fold3(input logic [2:0] v, input int unsigned m);
        logic [3:0] r;
        r = {1'b0, v};
        for (int k = 0; k < 8; k++) begin
            if (32'(r) >= m) begin
                r = r - 4'(m);
            end
        end
        return r[2:0];
    endfunction

    function automatic t_out make_res(input logic [1:0] st, input logic [2:0] dest,
                                      input logic [31:0] id, input logic [2:0] q,
                                      input logic [30:0] pr, input logic [31:0] pay);
        t_out r;
        r.status      = st;
        r.dest_client = dest;
        r.out_id      = id;
        r.out_queue   = q;
        r.out_prio    = pr;
        r.out_payload = pay;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

// ===== hdl/mqjs_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module mqjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/mqjs_fifo.sv =====
// short request queue between front and back
// depends on mqjs_pkg
module mqjs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mqjs_pkg::t_req i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mqjs_pkg::t_req o_data
);
    import mqjs_pkg::*;
    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    t_req           r_mem [FIFO_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [PW:0]    r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ===== hdl/mqjs_front.sv =====
// request intake: decodes the kind, folds client and queue numbers, masks queues
// depends on mqjs_pkg
module mqjs_front #(
    parameter int QUEUE_COUNT  = 8,
    parameter int CLIENT_COUNT = 8
) (
    input  logic           i_in_valid,
    input  mqjs_pkg::t_in  i_in,
    output logic           o_in_stall,
    input  logic           i_full,
    output logic           o_push,
    output mqjs_pkg::t_req o_req
);
    import mqjs_pkg::*;
    localparam logic [7:0] QMASK = (QUEUE_COUNT >= 8) ? 8'hFF : 8'((1 << QUEUE_COUNT) - 1);

    logic known;

    assign known      = (i_in.req_type <= 3'(K_DISC));
    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full && known;

    always_comb begin
        o_req.kind      = t_kind'(i_in.req_type);
        o_req.client    = fold3(i_in.client, CLIENT_COUNT);
        o_req.qsel      = fold3(i_in.queue_sel, QUEUE_COUNT);
        o_req.mask      = i_in.queue_mask & QMASK;
        o_req.wait_flag = i_in.wait_flag;
        o_req.prio      = i_in.prio;
        o_req.payload   = i_in.payload_tag;
        o_req.tid       = i_in.target_id;
    end
endmodule

// ===== hdl/mqjs_back.sv =====
// job table engine: slot scans, waiter selection, result sequencing
// depends on mqjs_pkg and mqjs_ram
module mqjs_back #(
    parameter int JOB_SLOTS    = 64,
    parameter int CLIENT_COUNT = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  mqjs_pkg::t_req i_req,
    output logic           o_req_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mqjs_pkg::t_out o_out
);
    import mqjs_pkg::*;
    localparam int SW = $clog2(JOB_SLOTS);
    localparam int CW = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;

    t_state          r_state, n_state;
    t_req            r_req;
    logic [JOB_SLOTS-1:0] r_valid, r_asgn;
    logic [31:0]     r_next_id;
    logic [7:0]      r_wmask  [CLIENT_COUNT];
    logic [15:0]     r_wstamp [CLIENT_COUNT];
    logic [15:0]     r_wcnt;
    logic [SW:0]     r_idx;
    logic            r_chk_v;
    logic [SW-1:0]   r_chk_idx;
    logic            r_bfound;
    logic [SW-1:0]   r_sel;
    t_job            r_sl;
    logic [CW-1:0]   r_wc, r_wbest;
    logic            r_wfound;
    logic [15:0]     r_wage;
    t_ret            r_ret;
    t_out            r_em;
    t_state          r_em_then;
    logic            r_hold_v;
    t_out            r_hold;
    logic            r_out_v;
    t_out            r_out;

    t_job            rd_job, new_job;
    logic [2:0]      rd_owner;
    logic            job_we, own_we;
    logic [2:0]      own_wdata;
    logic            push;
    t_out            push_res, deliv_res;
    logic            out_free, can_push;
    logic            s_valid, s_asgn;
    logic            m_free, m_get, m_abort, m_del, m_disc, get_better, get_upd;
    logic            scan_hit, scan_end;
    logic            wc_hit;
    logic [15:0]     w_age;
    logic [CW-1:0]   in_cidx;

    mqjs_ram #(.WIDTH($bits(t_job)), .DEPTH(JOB_SLOTS)) u_job_ram (
        .i_clk   (i_clk),
        .i_we    (job_we),
        .i_waddr (r_chk_idx),
        .i_wdata (new_job),
        .i_raddr (r_idx[SW-1:0]),
        .o_rdata (rd_job)
    );

    mqjs_ram #(.WIDTH(3), .DEPTH(JOB_SLOTS)) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (r_sel),
        .i_wdata (own_wdata),
        .i_raddr (r_idx[SW-1:0]),
        .o_rdata (rd_owner)
    );

    always_comb begin
        in_cidx       = CW'(i_req.client);
        new_job.queue   = r_req.qsel;
        new_job.prio    = r_req.prio;
        new_job.id      = r_next_id;
        new_job.payload = r_req.payload;
        s_valid    = r_valid[r_chk_idx];
        s_asgn     = r_asgn[r_chk_idx];
        m_free     = !s_valid;
        m_get      = s_valid && !s_asgn && r_req.mask[rd_job.queue];
        m_abort    = s_valid && s_asgn && (rd_owner == r_req.client) && (rd_job.id == r_req.tid);
        m_del      = s_valid && (rd_job.id == r_req.tid);
        m_disc     = s_valid && s_asgn && (rd_owner == r_req.client);
        get_better = !r_bfound || (rd_job.prio > r_sl.prio) ||
                     ((rd_job.prio == r_sl.prio) && (rd_job.queue < r_sl.queue));
        get_upd    = (r_req.kind == K_GET) && r_chk_v && m_get && get_better;
        scan_hit   = 1'b0;
        if (r_chk_v) begin
            unique case (r_req.kind)
                K_PUT:    scan_hit = m_free;
                K_ABORT:  scan_hit = m_abort;
                K_DELETE: scan_hit = m_del;
                K_DISC:   scan_hit = m_disc;
                default:  scan_hit = 1'b0;
            endcase
        end
        scan_end  = !r_chk_v && (r_idx == (SW+1)'(JOB_SLOTS));
        wc_hit    = r_wmask[r_wc][r_sl.queue];
        w_age     = r_wcnt - r_wstamp[r_wc];
        out_free  = !r_out_v || !i_out_stall;
        can_push  = !r_hold_v || out_free;
        deliv_res = make_res(STAT_DELIV, 3'(r_wbest), r_sl.id, r_sl.queue, r_sl.prio,
                             r_sl.payload);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && ((i_req.kind == K_DISC) || (r_wmask[in_cidx] == '0))) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    priority case (r_req.kind)
                        K_PUT, K_DISC: n_state = S_WSCAN;
                        default:       n_state = S_EMIT;
                    endcase
                end else if (scan_end) begin
                    priority if (r_req.kind == K_DISC) begin
                        n_state = S_FLUSH;
                    end else if ((r_req.kind == K_GET) && !r_bfound && r_req.wait_flag) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_WSCAN: begin
                if (r_wc == CW'(CLIENT_COUNT - 1)) begin
                    n_state = S_WDELIV;
                end
            end
            S_WDELIV: begin
                if (!r_wfound || can_push) begin
                    unique case (r_ret)
                        RET_EMIT:  n_state = S_EMIT;
                        RET_SCAN:  n_state = S_SCAN;
                        default:   n_state = S_FLUSH;
                    endcase
                end
            end
            S_EMIT: begin
                if (can_push) begin
                    n_state = r_em_then;
                end
            end
            S_FLUSH: begin
                if (!r_hold_v || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // strobes
    always_comb begin
        o_req_pop = 1'b0;
        push      = 1'b0;
        push_res  = r_em;
        job_we    = 1'b0;
        own_we    = 1'b0;
        own_wdata = r_req.client;
        unique case (r_state)
            S_IDLE:   o_req_pop = i_req_valid;
            S_SCAN: begin
                job_we = scan_hit && (r_req.kind == K_PUT);
                own_we = scan_end && !scan_hit && (r_req.kind == K_GET) && r_bfound;
            end
            S_WDELIV: begin
                if (r_wfound && can_push) begin
                    push      = 1'b1;
                    push_res  = deliv_res;
                    own_we    = 1'b1;
                    own_wdata = 3'(r_wbest);
                end
            end
            S_EMIT:   push = can_push;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_asgn    <= '0;
            r_next_id <= '0;
            r_wcnt    <= '0;
            r_hold_v  <= 1'b0;
            r_out_v   <= 1'b0;
            r_chk_v   <= 1'b0;
            r_bfound  <= 1'b0;
            r_wfound  <= 1'b0;
            for (int c = 0; c < CLIENT_COUNT; c++) begin
                r_wmask[c]  <= '0;
                r_wstamp[c] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (push) begin
                if (r_hold_v) begin
                    r_out   <= r_hold;
                    r_out_v <= 1'b1;
                end else if (out_free) begin
                    r_out_v <= 1'b0;
                end
                r_hold   <= push_res;
                r_hold_v <= 1'b1;
            end else if ((r_state == S_FLUSH) && r_hold_v && out_free) begin
                r_out      <= {r_hold[$bits(t_out)-1:1], 1'b1};
                r_out_v    <= 1'b1;
                r_hold_v   <= 1'b0;
            end else if (out_free) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req    <= i_req;
                        r_idx    <= '0;
                        r_chk_v  <= 1'b0;
                        r_bfound <= 1'b0;
                        if (i_req.kind == K_DISC) begin
                            r_wmask[in_cidx] <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        r_sel    <= r_chk_idx;
                        r_wc     <= '0;
                        r_wfound <= 1'b0;
                        r_chk_v  <= 1'b0;
                        unique case (r_req.kind)
                            K_PUT: begin
                                r_valid[r_chk_idx] <= 1'b1;
                                r_asgn[r_chk_idx]  <= 1'b0;
                                r_sl      <= new_job;
                                r_next_id <= r_next_id + 32'd1;
                                r_em      <= make_res(STAT_OK, r_req.client, r_next_id,
                                                      '0, '0, '0);
                                r_em_then <= S_FLUSH;
                                r_ret     <= RET_EMIT;
                            end
                            K_ABORT: begin
                                r_sl      <= rd_job;
                                r_em      <= make_res(STAT_OK, r_req.client, '0, '0, '0, '0);
                                r_em_then <= S_WSCAN;
                                r_ret     <= RET_FLUSH;
                            end
                            K_DELETE: begin
                                r_valid[r_chk_idx] <= 1'b0;
                                r_asgn[r_chk_idx]  <= 1'b0;
                                r_em      <= make_res(STAT_OK, r_req.client, '0, '0, '0, '0);
                                r_em_then <= S_FLUSH;
                            end
                            default: begin
                                r_sl  <= rd_job;
                                r_ret <= RET_SCAN;
                            end
                        endcase
                    end else begin
                        if (r_idx != (SW+1)'(JOB_SLOTS)) begin
                            r_chk_v   <= 1'b1;
                            r_chk_idx <= r_idx[SW-1:0];
                            r_idx     <= r_idx + 1'b1;
                        end else begin
                            r_chk_v <= 1'b0;
                        end
                        if (get_upd) begin
                            r_bfound <= 1'b1;
                            r_sel    <= r_chk_idx;
                            r_sl     <= rd_job;
                        end
                        if (scan_end) begin
                            r_em_then <= S_FLUSH;
                            priority if (r_req.kind == K_PUT) begin
                                r_em <= make_res(STAT_FULL, r_req.client, '0, '0, '0, '0);
                            end else if ((r_req.kind == K_GET) && r_bfound) begin
                                r_asgn[r_sel] <= 1'b1;
                                r_em <= make_res(STAT_DELIV, r_req.client, r_sl.id,
                                                 r_sl.queue, r_sl.prio, r_sl.payload);
                            end else if ((r_req.kind == K_GET) && r_req.wait_flag) begin
                                if (r_req.mask != '0) begin
                                    r_wmask[CW'(r_req.client)]  <= r_req.mask;
                                    r_wstamp[CW'(r_req.client)] <= r_wcnt;
                                    r_wcnt <= r_wcnt + 16'd1;
                                end
                            end else begin
                                r_em <= make_res(STAT_NONE, r_req.client, '0, '0, '0, '0);
                            end
                        end
                    end
                end
                S_WSCAN: begin
                    if (wc_hit && (!r_wfound || (w_age > r_wage))) begin
                        r_wfound <= 1'b1;
                        r_wbest  <= r_wc;
                        r_wage   <= w_age;
                    end
                    r_wc <= r_wc + 1'b1;
                end
                S_WDELIV: begin
                    if (!r_wfound) begin
                        r_asgn[r_sel] <= 1'b0;
                    end else if (can_push) begin
                        r_asgn[r_sel]    <= 1'b1;
                        r_wmask[r_wbest] <= '0;
                    end
                end
                S_EMIT: begin
                    if (can_push) begin
                        r_wc     <= '0;
                        r_wfound <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;
endmodule

// ===== hdl/multi_queue_priority_job_scheduler_top.sv =====
// one request at a time: a scan of the slot table, plus a waiter lookup where one is
// needed, then the results are sent
// throughput is set by the slot table scan; the back takes no new request until it is done
// the request queue holds up to two requests while the back is busy
// reset is synchronous active low, clears slot flags, waiters and counters at once
// depends on mqjs_pkg, mqjs_front, mqjs_fifo, mqjs_back, mqjs_ram
module multi_queue_priority_job_scheduler_top #(
    parameter int JOB_SLOTS    = 64,
    parameter int QUEUE_COUNT  = 8,
    parameter int CLIENT_COUNT = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  mqjs_pkg::t_in  i_in,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mqjs_pkg::t_out o_out
);
    import mqjs_pkg::*;

    logic w_push, w_full, w_pop, w_fvalid;
    t_req w_front_req, w_back_req;

    mqjs_front #(.QUEUE_COUNT(QUEUE_COUNT), .CLIENT_COUNT(CLIENT_COUNT)) u_front (
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_req      (w_front_req)
    );

    mqjs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_req),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_fvalid),
        .o_data  (w_back_req)
    );

    mqjs_back #(.JOB_SLOTS(JOB_SLOTS), .CLIENT_COUNT(CLIENT_COUNT)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_fvalid),
        .i_req       (w_back_req),
        .o_req_pop   (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("queue push while full");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_fvalid) else $error("queue pop while empty");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("result valid after reset");
endmodule
